### design/get_pkg.sv
// Shared types and constants for the graph edge table.
package get_pkg;

   localparam int TYPE_W   = 2;
   localparam int STATUS_W = 2;
   localparam int ID_W     = 32;
   localparam int COUNT_W  = 11;
   localparam int REQ_DATA_W = 2 * ID_W;
   localparam int RSP_DATA_W = ((2 * COUNT_W + ID_W + 7) / 8) * 8;

   typedef enum logic [TYPE_W-1:0] {
      OP_ADD_EDGE   = 2'd0,
      OP_DEL_EDGE   = 2'd1,
      OP_DEL_VERTEX = 2'd2,
      OP_NOP        = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_SCAN  = 5'b00100,
      S_FIX   = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

endpackage

### design/get_ram.sv
// Single-port-write, single-port-read RAM with registered read data.
module get_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/graph_edge_table.sv
// Graph edge table: bounded multiset of directed edges with add/remove/vertex-remove requests.
//
// Edges live in one RAM of EDGE_SLOTS words, each holding a valid mark, the source and the
// target. After reset the block sweeps the RAM clearing every slot, one slot a cycle, and
// takes no request meanwhile. Add, remove-edge and remove-vertex requests then scan the
// whole table through the RAM read port one slot per cycle; an undirected edge removal that
// also finds its reverse clears the reverse in a further step after the scan. An add that
// finds too little room and an unused request type answer without a scan. One request is
// worked on at a time; a new one is accepted while the previous response still waits on the
// response channel.
module graph_edge_table #(
   parameter int EDGE_SLOTS  = 1024,
   parameter int VERTEX_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wen,
   input  logic                              csr_wdata,   // undirected_mode
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [get_pkg::REQ_DATA_W-1:0]    req_tdata,   // src_vertex, dst_vertex
   input  logic [get_pkg::TYPE_W-1:0]        req_tuser,   // req_type
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [get_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // edge_count, highest_vertex,
                                                          // removed_count, zero pad
   output logic [get_pkg::STATUS_W-1:0]      rsp_tuser    // status
);

   import get_pkg::*;

   localparam int AW = $clog2(EDGE_SLOTS);
   localparam int CW = $clog2(EDGE_SLOTS + 1);
   localparam int VB = VERTEX_BITS;
   localparam int WW = 2 * VB + 1;

   localparam logic [AW:0]   SLOTS_END = (AW + 1)'(EDGE_SLOTS);
   localparam logic [CW-1:0] CNT_FULL  = CW'(EDGE_SLOTS);
   localparam logic [CW-1:0] CNT_FULL2 = CW'(EDGE_SLOTS - 1);

   state_type        state_ff, state_in;
   logic             undirected_ff, undirected_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [VB-1:0]    top_ff, top_in;
   logic [AW:0]      issue_ff, issue_in;
   logic             eval_vld_ff, eval_vld_in;
   logic [AW-1:0]    eval_addr_ff, eval_addr_in;
   op_type           op_ff, op_in;
   logic [VB-1:0]    src_ff, src_in;
   logic [VB-1:0]    dst_ff, dst_in;
   status_type       status_ff, status_in;
   logic [CW-1:0]    removed_ff, removed_in;
   logic             first_ff, first_in;
   logic             second_ff, second_in;
   logic [AW-1:0]    rev_addr_ff, rev_addr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [CW-1:0]    rsp_count_ff, rsp_count_in;
   logic [VB-1:0]    rsp_top_ff, rsp_top_in;
   logic [CW-1:0]    rsp_removed_ff, rsp_removed_in;

   logic             ram_wr_en;
   logic [AW-1:0]    ram_wr_addr;
   logic [WW-1:0]    ram_wr_data;
   logic [WW-1:0]    ram_rd_data;

   logic [ID_W+VB-1:0]      req_src_ext, req_dst_ext;
   logic [VB-1:0]           req_src, req_dst;
   logic [VB-1:0]           top_max1, top_add, top_del;
   logic                    ent_vld;
   logic [VB-1:0]           ent_src, ent_dst;
   logic                    issuing, full;
   logic [CW+COUNT_W-1:0]   cnt_ext, rem_ext;
   logic [VB+ID_W-1:0]      top_ext;

   get_ram #(.WIDTH(WW), .DEPTH(EDGE_SLOTS)) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (issue_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   assign req_src_ext = {{VB{1'b0}}, req_tdata[ID_W-1:0]};
   assign req_dst_ext = {{VB{1'b0}}, req_tdata[2*ID_W-1:ID_W]};
   assign req_src     = req_src_ext[VB-1:0];
   assign req_dst     = req_dst_ext[VB-1:0];

   assign top_max1 = (req_src > top_ff) ? req_src : top_ff;
   assign top_add  = (req_dst > top_max1) ? req_dst : top_max1;
   assign top_del  = (req_src == top_ff && top_ff != '0) ? top_ff - VB'(1) : top_ff;

   assign ent_vld = ram_rd_data[WW-1];
   assign ent_src = ram_rd_data[2*VB-1:VB];
   assign ent_dst = ram_rd_data[VB-1:0];

   assign issuing = (issue_ff < SLOTS_END);
   assign full    = undirected_ff ? (count_ff >= CNT_FULL2) : (count_ff == CNT_FULL);

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in       = state_ff;
      undirected_in  = csr_wen ? csr_wdata : undirected_ff;
      count_in       = count_ff;
      top_in         = top_ff;
      issue_in       = issue_ff;
      eval_vld_in    = 1'b0;
      eval_addr_in   = issue_ff[AW-1:0];
      op_in          = op_ff;
      src_in         = src_ff;
      dst_in         = dst_ff;
      status_in      = status_ff;
      removed_in     = removed_ff;
      first_in       = first_ff;
      second_in      = second_ff;
      rev_addr_in    = rev_addr_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_top_in     = rsp_top_ff;
      rsp_removed_in = rsp_removed_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = eval_addr_ff;
      ram_wr_data    = '0;

      unique case (state_ff)
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = issue_ff[AW-1:0];
            issue_in    = issue_ff + (AW + 1)'(1);
            if (issue_ff == SLOTS_END - (AW + 1)'(1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               op_in      = op_type'(req_tuser);
               src_in     = req_src;
               dst_in     = req_dst;
               status_in  = ST_OK;
               removed_in = '0;
               first_in   = 1'b0;
               second_in  = 1'b0;
               issue_in   = '0;
               unique case (op_type'(req_tuser))
                  OP_ADD_EDGE: begin
                     if (full) begin
                        status_in = ST_FULL;
                        state_in  = S_DONE;
                     end else begin
                        top_in   = top_add;
                        state_in = S_SCAN;
                     end
                  end
                  OP_DEL_EDGE: state_in = S_SCAN;
                  OP_DEL_VERTEX: begin
                     top_in   = top_del;
                     state_in = S_SCAN;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_SCAN: begin
            if (issuing) begin
               issue_in    = issue_ff + (AW + 1)'(1);
               eval_vld_in = 1'b1;
            end
            if (eval_vld_ff) begin
               case (op_ff)
                  OP_ADD_EDGE: begin
                     if (!ent_vld && !first_ff) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = {1'b1, src_ff, dst_ff};
                        first_in    = 1'b1;
                        count_in    = count_ff + CW'(1);
                     end else if (!ent_vld && undirected_ff && !second_ff) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = {1'b1, dst_ff, src_ff};
                        second_in   = 1'b1;
                        count_in    = count_ff + CW'(1);
                     end
                  end
                  OP_DEL_EDGE: begin
                     if (ent_vld && ent_src == src_ff && ent_dst == dst_ff && !first_ff) begin
                        ram_wr_en  = 1'b1;
                        first_in   = 1'b1;
                        removed_in = CW'(1);
                        count_in   = count_ff - CW'(1);
                     end else if (ent_vld && ent_src == dst_ff && ent_dst == src_ff
                                  && undirected_ff && !second_ff) begin
                        second_in   = 1'b1;
                        rev_addr_in = eval_addr_ff;
                     end
                  end
                  OP_DEL_VERTEX: begin
                     if (ent_vld && (ent_src == src_ff || ent_dst == src_ff)) begin
                        ram_wr_en  = 1'b1;
                        removed_in = removed_ff + CW'(1);
                        count_in   = count_ff - CW'(1);
                     end
                  end
                  default: ;
               endcase
            end
            if (!issuing && !eval_vld_ff) begin
               state_in = S_DONE;
               if (op_ff == OP_DEL_EDGE) begin
                  if (!first_ff) begin
                     status_in = ST_NOT_FOUND;
                  end else if (second_ff) begin
                     state_in = S_FIX;
                  end
               end
            end
         end
         S_FIX: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = rev_addr_ff;
            removed_in  = removed_ff + CW'(1);
            count_in    = count_ff - CW'(1);
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_count_in   = count_ff;
               rsp_top_in     = top_ff;
               rsp_removed_in = removed_ff;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         undirected_ff <= 1'b0;
         count_ff      <= '0;
         top_ff        <= '0;
         issue_ff      <= '0;
         eval_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         undirected_ff <= undirected_in;
         count_ff      <= count_in;
         top_ff        <= top_in;
         issue_ff      <= issue_in;
         eval_vld_ff   <= eval_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      eval_addr_ff   <= eval_addr_in;
      op_ff          <= op_in;
      src_ff         <= src_in;
      dst_ff         <= dst_in;
      status_ff      <= status_in;
      removed_ff     <= removed_in;
      first_ff       <= first_in;
      second_ff      <= second_in;
      rev_addr_ff    <= rev_addr_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_top_ff     <= rsp_top_in;
      rsp_removed_ff <= rsp_removed_in;
   end

   assign cnt_ext = {{COUNT_W{1'b0}}, rsp_count_ff};
   assign rem_ext = {{COUNT_W{1'b0}}, rsp_removed_ff};
   assign top_ext = {{ID_W{1'b0}}, rsp_top_ff};

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - 2 * COUNT_W - ID_W){1'b0}},
                        rem_ext[COUNT_W-1:0], top_ext[ID_W-1:0], cnt_ext[COUNT_W-1:0]};

endmodule

### dv/tb_graph_edge_table.sv
// Self-checking testbench for the graph edge table: directed and random requests.
`timescale 1ns / 100ps
module tb_graph_edge_table;
   import get_pkg::*;

   localparam int SLOTS = 1024;

   typedef struct {
      status_type         status;
      logic [COUNT_W-1:0] edge_count;
      logic [ID_W-1:0]    highest;
      logic [COUNT_W-1:0] removed;
   } edge_reply_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_wen    = 1'b0;
   logic                  csr_wdata  = 1'b0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [TYPE_W-1:0]     req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;

   // predicted table contents
   logic [ID_W-1:0] tbl_src [SLOTS];
   logic [ID_W-1:0] tbl_dst [SLOTS];
   bit              tbl_used [SLOTS];
   int              edges_held = 0;
   logic [ID_W-1:0] top_id = '0;
   bit              mirror = 1'b0;

   edge_reply_type  replies_due [$];
   edge_reply_type  oldest;
   bit              failed = 1'b0;
   bit              calm = 1'b0;
   int              stall_left = 0;

   graph_edge_table uut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   function automatic int lookup_edge(logic [ID_W-1:0] s, logic [ID_W-1:0] d);
      for (int i = 0; i < SLOTS; i++)
         if (tbl_used[i] && tbl_src[i] == s && tbl_dst[i] == d) return i;
      return -1;
   endfunction

   function automatic void insert_edge(logic [ID_W-1:0] s, logic [ID_W-1:0] d);
      for (int i = 0; i < SLOTS; i++)
         if (!tbl_used[i]) begin
            tbl_src[i]  = s;
            tbl_dst[i]  = d;
            tbl_used[i] = 1'b1;
            edges_held++;
            return;
         end
   endfunction

   function automatic edge_reply_type apply_request(op_type op, logic [ID_W-1:0] s,
                                                    logic [ID_W-1:0] d);
      edge_reply_type r;
      int             k;
      r.status  = ST_OK;
      r.removed = '0;
      case (op)
         OP_ADD_EDGE: begin
            if (SLOTS - edges_held < (mirror ? 2 : 1)) begin
               r.status = ST_FULL;
            end else begin
               insert_edge(s, d);
               if (mirror) insert_edge(d, s);
               if (s > top_id) top_id = s;
               if (d > top_id) top_id = d;
            end
         end
         OP_DEL_EDGE: begin
            k = lookup_edge(s, d);
            if (k < 0) begin
               r.status = ST_NOT_FOUND;
            end else begin
               tbl_used[k] = 1'b0;
               edges_held--;
               r.removed = 1;
               if (mirror) begin
                  k = lookup_edge(d, s);
                  if (k >= 0) begin
                     tbl_used[k] = 1'b0;
                     edges_held--;
                     r.removed = 2;
                  end
               end
            end
         end
         OP_DEL_VERTEX: begin
            for (int i = 0; i < SLOTS; i++)
               if (tbl_used[i] && (tbl_src[i] == s || tbl_dst[i] == s)) begin
                  tbl_used[i] = 1'b0;
                  edges_held--;
                  r.removed = r.removed + 1'b1;
               end
            if (s == top_id && top_id != 0) top_id = top_id - 1'b1;
         end
         default: ;
      endcase
      r.edge_count = edges_held[COUNT_W-1:0];
      r.highest    = top_id;
      return r;
   endfunction

   task automatic send_request(op_type op, logic [ID_W-1:0] s, logic [ID_W-1:0] d);
      @(negedge clock);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {d, s};
      do @(posedge clock); while (!req_tready);
      replies_due.push_back(apply_request(op, s, d));
   endtask

   task automatic drain;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_mirror(bit m);
      drain;
      csr_wen   <= 1'b1;
      csr_wdata <= m;
      @(negedge clock);
      csr_wen   <= 1'b0;
      mirror = m;
   endtask

   task automatic check_field(string field, logic [ID_W-1:0] want, logic [ID_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         failed = 1'b1;
      end
   endtask

   always @(negedge clock) begin
      if (calm) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 8);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (replies_due.size() == 0) begin
            $error("response with no request outstanding");
            failed = 1'b1;
         end else begin
            oldest = replies_due.pop_front();
            check_field("status", oldest.status, rsp_tuser);
            check_field("edge_count", oldest.edge_count, rsp_tdata[COUNT_W-1:0]);
            check_field("highest_vertex", oldest.highest,
                        rsp_tdata[COUNT_W+ID_W-1:COUNT_W]);
            check_field("removed_count", oldest.removed,
                        rsp_tdata[2*COUNT_W+ID_W-1:COUNT_W+ID_W]);
         end
      end
   end

   task automatic test_directed_edges;
      set_mirror(1'b0);
      send_request(OP_DEL_EDGE, 32'd5, 32'd6);                 // empty table
      send_request(OP_DEL_VERTEX, 32'd0, 32'hFFFF_FFFF);       // top already zero
      send_request(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(OP_ADD_EDGE, 32'd0, 32'd0);
      send_request(OP_ADD_EDGE, 32'hFFFF_FFFF, 32'd1);
      send_request(OP_ADD_EDGE, 32'd1, 32'hFFFF_FFFF);
      send_request(OP_ADD_EDGE, 32'd5, 32'd6);
      send_request(OP_ADD_EDGE, 32'd5, 32'd6);                 // duplicate copy
      send_request(OP_DEL_EDGE, 32'd5, 32'd6);
      send_request(OP_DEL_EDGE, 32'd6, 32'd5);                 // reverse never stored
      send_request(OP_DEL_VERTEX, 32'hFFFF_FFFF, 32'd0);
      send_request(OP_DEL_VERTEX, 32'hFFFF_FFFE, 32'd0);       // absent, top still drops
      send_request(OP_ADD_EDGE, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
      send_request(OP_ADD_EDGE, 32'd10, 32'd11);
   endtask

   task automatic test_undirected_edges;
      set_mirror(1'b1);
      send_request(OP_DEL_EDGE, 32'd10, 32'd11);               // reverse missing
      send_request(OP_ADD_EDGE, 32'd7, 32'd8);
      send_request(OP_ADD_EDGE, 32'd9, 32'd9);                 // self loop, two slots
      send_request(OP_DEL_EDGE, 32'd8, 32'd7);
      send_request(OP_DEL_EDGE, 32'd9, 32'd9);
      send_request(OP_DEL_EDGE, 32'd9, 32'd9);
      send_request(OP_DEL_VERTEX, 32'd0, 32'd0);
      send_request(OP_DEL_VERTEX, 32'hA5A5_A5A5, 32'd0);
      send_request(OP_NOP, 32'd0, 32'd0);
   endtask

   task automatic test_random_mix(bit m, int n);
      logic [ID_W-1:0] pool [8];
      logic [ID_W-1:0] s, d;
      int              pick, k;
      set_mirror(m);
      foreach (pool[i]) pool[i] = (i < 4) ? ID_W'(i) : ID_W'($urandom);
      repeat (n) begin
         s    = pool[$urandom_range(0, 7)];
         d    = pool[$urandom_range(0, 7)];
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            send_request(OP_ADD_EDGE, s, d);
         end else if (pick < 72 && edges_held > 0) begin
            do k = $urandom_range(0, SLOTS - 1); while (!tbl_used[k]);
            if ($urandom_range(0, 1))
               send_request(OP_DEL_EDGE, tbl_src[k], tbl_dst[k]);
            else
               send_request(OP_DEL_EDGE, tbl_dst[k], tbl_src[k]);
         end else if (pick < 80) begin
            send_request(OP_ADD_EDGE, $urandom, $urandom);
         end else if (pick < 87) begin
            send_request(OP_DEL_EDGE, s, d);
         end else if (pick < 96) begin
            send_request(OP_DEL_VERTEX, s, $urandom);
         end else begin
            send_request(OP_NOP, $urandom, $urandom);
         end
      end
   endtask

   task automatic test_table_full;
      logic [ID_W-1:0] hub, s, d;
      int              k;
      calm = 1'b1;
      set_mirror(1'b1);
      hub = $urandom;
      while (edges_held < SLOTS - 1) begin
         s = $urandom;
         d = $urandom;
         case ($urandom_range(0, 7))
            0: s = hub;
            1: d = hub;
            2: d = s;
            default: ;
         endcase
         send_request(OP_ADD_EDGE, s, d);
      end
      send_request(OP_ADD_EDGE, $urandom, $urandom);
      set_mirror(1'b0);
      if (edges_held == SLOTS) begin
         do k = $urandom_range(0, SLOTS - 1); while (!tbl_used[k]);
         send_request(OP_DEL_EDGE, tbl_src[k], tbl_dst[k]);
      end
      set_mirror(1'b1);
      send_request(OP_ADD_EDGE, 32'd3, 32'd4);                 // one slot free, two needed
      set_mirror(1'b0);
      send_request(OP_ADD_EDGE, 32'd3, 32'd4);
      send_request(OP_ADD_EDGE, 32'd5, 32'd6);
      send_request(OP_DEL_VERTEX, hub, 32'd0);
      send_request(OP_ADD_EDGE, hub, hub);
      send_request(OP_DEL_EDGE, 32'd3, 32'd4);
      send_request(OP_DEL_EDGE, 32'd3, 32'd4);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_edges;
      test_undirected_edges;
      test_random_mix(1'b0, 30);
      test_random_mix(1'b1, 30);
      test_table_full;
      drain;
      repeat (SLOTS + 8) @(posedge clock);
      if (failed)
         $display("Some tests failed");
      else
         $display("All tests passed");
      $finish;
   end

   initial begin
      #15_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
